FILE: rtl/core/plist_pkg.sv
package plist_pkg;

  // default sizing
  localparam int DEF_CAPACITY   = 32;
  localparam int DEF_DATA_WIDTH = 32;

  // fixed field widths
  localparam int OP_W     = 2;
  localparam int POS_W    = 6;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int ELEM_W   = 32;
  localparam int LEN_W    = 6;

  localparam int S_TDATA_W = 40;  // position + value, padded to bytes
  localparam int M_TDATA_W = 40;  // element + length, padded to bytes

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_DUMP   = 2'd2,
    OP_SPARE  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  // per-cycle move applied along the chain
  typedef enum logic [1:0] {
    MODE_HOLD = 2'd0,
    MODE_INS  = 2'd1,
    MODE_DEL  = 2'd2,
    MODE_ROT  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

endpackage

FILE: rtl/core/plist_cell.sv
module plist_cell #(
  parameter int DATA_WIDTH = plist_pkg::DEF_DATA_WIDTH,
  parameter int CAPACITY   = plist_pkg::DEF_CAPACITY,
  parameter int INDEX      = 0
) (
  input  logic                            clk,
  input  plist_pkg::mode_t                mode,
  input  logic [$clog2(CAPACITY)-1:0]     idx,   // insert/delete slot
  input  logic [$clog2(CAPACITY)-1:0]     tail,  // last occupied slot
  input  logic [DATA_WIDTH-1:0]           left,  // neighbor toward front
  input  logic [DATA_WIDTH-1:0]           right, // neighbor toward back
  input  logic [DATA_WIDTH-1:0]           head,  // slot 0, for rotation wrap
  input  logic [DATA_WIDTH-1:0]           din,
  output logic [DATA_WIDTH-1:0]           q
);
  import plist_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

  logic [DATA_WIDTH-1:0] q_next;

  always_comb begin
    q_next = q;
    case (mode)
      MODE_INS: begin
        if (MY_IDX > idx) q_next = left;
        else if (MY_IDX == idx) q_next = din;
      end
      MODE_DEL: begin
        if (MY_IDX >= idx) q_next = right;
      end
      MODE_ROT: begin
        if (MY_IDX < tail) q_next = right;
        else if (MY_IDX == tail) q_next = head;
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

FILE: rtl/core/positional_list_insert_delete.sv
// Results: insert and delete register their single result in the cycle after the
//   input; a dump's first value goes through the state and output registers.
// Insert/delete take new input whenever the output is free; a dump holds off input
//   until its last value, one per cycle as the chain rotates, unless output stalls.
// Reset (rst, synchronous, active high) empties the list and idles the output.
//   Cell contents are not cleared; only occupied slots are ever read.
module positional_list_insert_delete #(
  parameter int CAPACITY   = plist_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = plist_pkg::DEF_DATA_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [plist_pkg::S_TDATA_W-1:0]    s_tdata,  // position[5:0], value[37:6]
  input  logic [plist_pkg::OP_W-1:0]         s_tuser,  // op[1:0]
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [plist_pkg::M_TDATA_W-1:0]    m_tdata,  // element[31:0], length[37:32]
  output logic [plist_pkg::STATUS_W-1:0]     m_tuser,  // status[1:0]
  output logic                               m_tlast
);
  import plist_pkg::*;

  localparam int IW   = $clog2(CAPACITY);
  localparam int FW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((FW > POS_W) ? FW : POS_W) + 1;

  // ---------------------------------------------------------------- input
  logic [POS_W-1:0] pos;
  logic [VAL_W-1:0] val;
  op_t              op;
  logic             s_fire;

  assign pos    = s_tdata[POS_W-1:0];
  assign val    = s_tdata[POS_W+VAL_W-1:POS_W];
  assign op     = op_t'(s_tuser);
  assign s_fire = s_tvalid && s_tready;

  // ------------------------------------------------------------- control
  state_t          state, state_next;
  logic [FW-1:0]   fill, fill_next;
  logic [IW-1:0]   cnt;
  logic            out_free;

  logic [CMPW-1:0] pos_ext, fill_ext;
  logic            full, ins_ok, del_ok;
  logic [POS_W-1:0] pos_m1;
  logic [IW-1:0]   idx, tail;
  logic            last_elem;
  mode_t           mode;

  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE) && out_free;

  assign pos_ext   = CMPW'(pos);
  assign fill_ext  = CMPW'(fill);
  assign full      = (fill == FW'(CAPACITY));
  assign ins_ok    = !full && (pos != '0) && (pos_ext <= fill_ext + CMPW'(1));
  assign del_ok    = (pos != '0) && (pos_ext <= fill_ext);
  assign pos_m1    = pos - POS_W'(1);
  assign idx       = pos_m1[IW-1:0];
  // fill >= 1 whenever the chain rotates
  assign tail      = IW'(fill - FW'(1));
  assign last_elem = (cnt == tail);

  always_comb begin
    mode      = MODE_HOLD;
    fill_next = fill;
    if (s_fire && op == OP_INSERT && ins_ok) begin
      mode      = MODE_INS;
      fill_next = fill + FW'(1);
    end else if (s_fire && op == OP_DELETE && del_ok) begin
      mode      = MODE_DEL;
      fill_next = fill - FW'(1);
    end else if (state == S_DUMP && out_free) begin
      mode = MODE_ROT;
    end
  end

  // ------------------------------------------------------- value formats
  logic [DATA_WIDTH-1:0] din;
  logic [DATA_WIDTH-1:0] cells [CAPACITY];
  logic [ELEM_W-1:0]     head_elem;
  logic [LEN_W-1:0]      len_next;

  generate
    if (DATA_WIDTH > VAL_W) begin : g_din_wide
      assign din = {{(DATA_WIDTH-VAL_W){val[VAL_W-1]}}, val};
    end else if (DATA_WIDTH == VAL_W) begin : g_din_eq
      assign din = val;
    end else begin : g_din_narrow
      assign din = val[DATA_WIDTH-1:0];
    end

    if (DATA_WIDTH > ELEM_W) begin : g_el_wide
      assign head_elem = cells[0][ELEM_W-1:0];
    end else if (DATA_WIDTH == ELEM_W) begin : g_el_eq
      assign head_elem = cells[0];
    end else begin : g_el_narrow
      // sign-extend stored value into the element field
      assign head_elem = {{(ELEM_W-DATA_WIDTH){cells[0][DATA_WIDTH-1]}}, cells[0]};
    end

    if (FW >= LEN_W) begin : g_len_trunc
      assign len_next = fill_next[LEN_W-1:0];
    end else begin : g_len_ext
      assign len_next = {{(LEN_W-FW){1'b0}}, fill_next};
    end
  endgenerate

  // ---------------------------------------------------------- cell chain
  // Slots from the given position on shift toward the back on insert and toward
  // the front on delete, and rotate within the occupied range during a dump so
  // that slot 0 always holds the next value to send.
  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_d, right_d;
      if (i == 0) begin : g_first
        assign left_d = din;
      end else begin : g_mid_l
        assign left_d = cells[i-1];
      end
      if (i == CAPACITY - 1) begin : g_lastc
        assign right_d = cells[0];
      end else begin : g_mid_r
        assign right_d = cells[i+1];
      end

      plist_cell #(
        .DATA_WIDTH(DATA_WIDTH),
        .CAPACITY  (CAPACITY),
        .INDEX     (i)
      ) u_cell (
        .clk  (clk),
        .mode (mode),
        .idx  (idx),
        .tail (tail),
        .left (left_d),
        .right(right_d),
        .head (cells[0]),
        .din  (din),
        .q    (cells[i])
      );
    end
  endgenerate

  // ------------------------------------------------------ state and count
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_fire && op != OP_INSERT && op != OP_DELETE && fill != '0)
          state_next = S_DUMP;
      end
      S_DUMP: begin
        if (out_free && last_elem) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (s_fire) cnt <= '0;
      else if (state == S_DUMP && out_free) cnt <= cnt + IW'(1);
    end
  end

  // ------------------------------------------------------ output register
  status_t           out_status;
  logic [ELEM_W-1:0] out_elem;
  logic [LEN_W-1:0]  out_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready) m_tvalid <= 1'b0;
      if (s_fire) begin
        if (op == OP_INSERT || op == OP_DELETE || fill == '0) m_tvalid <= 1'b1;
      end else if (state == S_DUMP && out_free) begin
        m_tvalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      out_elem <= '0;
      m_tlast  <= 1'b1;
      out_len  <= len_next;
      case (op)
        OP_INSERT: out_status <= full ? ST_FULL : (ins_ok ? ST_OK : ST_BAD_POS);
        OP_DELETE: out_status <= del_ok ? ST_OK : ST_BAD_POS;
        default:   out_status <= ST_EMPTY;  // only reported when empty
      endcase
    end else if (state == S_DUMP && out_free) begin
      out_status <= ST_OK;
      out_elem   <= head_elem;
      m_tlast    <= last_elem;
      out_len    <= len_next;
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {{(M_TDATA_W-ELEM_W-LEN_W){1'b0}}, out_len, out_elem};

endmodule

FILE: rtl/core/plist_checker.sv
module plist_checker #(
  parameter int CAPACITY = plist_pkg::DEF_CAPACITY
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [plist_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [plist_pkg::STATUS_W-1:0]  m_tuser,
  input logic                            m_tlast
);
  import plist_pkg::*;

  localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  // no new input while a result is stuck
  a_backpr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while output stalled");

  // non-ok results are single and carry no element
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tlast && m_tdata[ELEM_W-1:0] == '0)
    else $error("error result malformed");

  // full status reports a full list
  a_full_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_FULL |-> m_tdata[ELEM_W+LEN_W-1:ELEM_W] == CAP_LEN)
    else $error("full status with wrong length");

  // empty status reports length zero
  a_empty_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_EMPTY |-> m_tdata[ELEM_W+LEN_W-1:ELEM_W] == '0)
    else $error("empty status with nonzero length");

endmodule

bind positional_list_insert_delete plist_checker #(.CAPACITY(CAPACITY)) u_plist_checker (.*);
